[hdl/alu8f_pkg.sv]
// Shared types and constants for the 8-bit CPU ALU with flags.
// No dependencies; imported by alu8f_core and eight_bit_cpu_alu_flags.
`default_nettype none

package alu8f_pkg;

    // Operation codes
    typedef enum logic [5:0] {
        OP_ADD    = 6'd0,
        OP_ADC    = 6'd1,
        OP_SUB    = 6'd2,
        OP_SBC    = 6'd3,
        OP_AND    = 6'd4,
        OP_XOR    = 6'd5,
        OP_OR     = 6'd6,
        OP_CP     = 6'd7,
        OP_INC    = 6'd8,
        OP_DEC    = 6'd9,
        OP_DAA    = 6'd10,
        OP_CPL    = 6'd11,
        OP_RLCA   = 6'd12,
        OP_RRCA   = 6'd13,
        OP_RLA    = 6'd14,
        OP_RRA    = 6'd15,
        OP_RLC    = 6'd16,
        OP_RRC    = 6'd17,
        OP_RL     = 6'd18,
        OP_RR     = 6'd19,
        OP_SLA    = 6'd20,
        OP_SRA    = 6'd21,
        OP_SRL    = 6'd22,
        OP_SWAP   = 6'd23,
        OP_BIT    = 6'd24,
        OP_SET    = 6'd25,
        OP_RES    = 6'd26,
        OP_CCF    = 6'd27,
        OP_SCF    = 6'd28,
        OP_ADDHL  = 6'd29,
        OP_ADDSP  = 6'd30,
        OP_INC16  = 6'd31,
        OP_DEC16  = 6'd32
    } t_alu_op;

    // Flag word: z in bit 3 down to c in bit 0
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // One input transaction
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [2:0]  bit_index;
        t_flags      flags;
    } t_alu_in;

    // Decimal adjust constants
    localparam logic [3:0]  DAA_NIB_MAX = 4'h9;
    localparam logic [8:0]  DAA_LOW_ADJ = 9'h006;
    localparam logic [8:0]  DAA_HI_ADJ  = 9'h060;
    localparam logic [8:0]  DAA_HI_MAX  = 9'h09f;
    localparam logic [3:0]  NIB_ALL     = 4'hf;
    localparam logic [11:0] H16_MASK    = 12'hfff;

endpackage

`default_nettype wire

[hdl/alu8f_core.sv]
// Combinational ALU datapath: result and Z/N/H/C flags for one operation.
// Depends on alu8f_pkg for the operation codes and the flag and item types.
`default_nettype none

module alu8f_core (
    input  alu8f_pkg::t_alu_in i_item,
    output logic [15:0]        o_result,
    output alu8f_pkg::t_flags  o_flags
);
    import alu8f_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic        cc;
    logic [8:0]  add9;
    logic [4:0]  add_h5;
    logic [8:0]  sub9;
    logic [4:0]  sub_h5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] hl17;
    logic [12:0] hl_h13;
    logic [15:0] sp16;
    logic [4:0]  sp_h5;
    logic [8:0]  sp_c9;
    logic [7:0]  mask8;
    logic [8:0]  daa_t1;
    logic [8:0]  daa_t2;
    logic [7:0]  daa_sub;
    logic [7:0]  daa_res;
    logic        daa_c;

    assign a8  = i_item.a[7:0];
    assign b8  = i_item.b[7:0];
    assign cin = i_item.flags.c;
    assign cc  = ((i_item.op == OP_ADC) || (i_item.op == OP_SBC)) ? cin : 1'b0;

    // 8-bit add and subtract with half and full carry
    assign add9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cc};
    assign add_h5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cc};
    assign sub9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cc};
    assign sub_h5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cc};
    assign inc8   = a8 + 8'd1;
    assign dec8   = a8 - 8'd1;

    // 16-bit adds
    assign hl17   = {1'b0, i_item.a} + {1'b0, i_item.b};
    assign hl_h13 = {1'b0, i_item.a[11:0] & H16_MASK} + {1'b0, i_item.b[11:0] & H16_MASK};
    assign sp16   = i_item.a + {{8{b8[7]}}, b8};
    assign sp_h5  = {1'b0, i_item.a[3:0]} + {1'b0, b8[3:0]};
    assign sp_c9  = {1'b0, i_item.a[7:0]} + {1'b0, b8};

    assign mask8 = 8'd1 << i_item.bit_index;

    // Decimal adjust: add path keeps the ninth bit for the carry out
    assign daa_t1 = (i_item.flags.h || (a8[3:0] > DAA_NIB_MAX))
                    ? ({1'b0, a8} + DAA_LOW_ADJ) : {1'b0, a8};
    assign daa_t2 = (cin || (daa_t1 > DAA_HI_MAX)) ? (daa_t1 + DAA_HI_ADJ) : daa_t1;
    // Subtract path: the carry out equals the carry in
    assign daa_sub = a8 - (i_item.flags.h ? DAA_LOW_ADJ[7:0] : 8'd0)
                        - (cin ? DAA_HI_ADJ[7:0] : 8'd0);
    assign daa_res = i_item.flags.n ? daa_sub : daa_t2[7:0];
    assign daa_c   = i_item.flags.n ? cin : (cin | daa_t2[8]);

    // Select result and flags by operation
    always_comb begin
        o_result = i_item.a;
        o_flags  = i_item.flags;
        case (i_item.op)
            OP_ADD, OP_ADC: begin
                o_result = {8'd0, add9[7:0]};
                o_flags  = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: add_h5[4], c: add9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                if (i_item.op != OP_CP) begin
                    o_result = {8'd0, sub9[7:0]};
                end
                o_flags = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: sub_h5[4], c: sub9[8]};
            end
            OP_AND: begin
                o_result = {8'd0, a8 & b8};
                o_flags  = '{z: ((a8 & b8) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR: begin
                o_result = {8'd0, a8 ^ b8};
                o_flags  = '{z: ((a8 ^ b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR: begin
                o_result = {8'd0, a8 | b8};
                o_flags  = '{z: ((a8 | b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC: begin
                o_result = {8'd0, inc8};
                o_flags  = '{z: (inc8 == 8'd0), n: 1'b0, h: (inc8[3:0] == 4'd0), c: cin};
            end
            OP_DEC: begin
                o_result = {8'd0, dec8};
                o_flags  = '{z: (dec8 == 8'd0), n: 1'b1, h: (dec8[3:0] == NIB_ALL), c: cin};
            end
            OP_DAA: begin
                o_result = {8'd0, daa_res};
                o_flags  = '{z: (daa_res == 8'd0), n: i_item.flags.n, h: 1'b0, c: daa_c};
            end
            OP_CPL: begin
                o_result = {8'd0, ~a8};
                o_flags  = '{z: i_item.flags.z, n: 1'b1, h: 1'b1, c: cin};
            end
            OP_RLCA, OP_RLC: begin
                o_result = {8'd0, a8[6:0], a8[7]};
                o_flags  = '{z: (i_item.op == OP_RLC) && (a8 == 8'd0),
                             n: 1'b0, h: 1'b0, c: a8[7]};
            end
            OP_RRCA, OP_RRC: begin
                o_result = {8'd0, a8[0], a8[7:1]};
                o_flags  = '{z: (i_item.op == OP_RRC) && (a8 == 8'd0),
                             n: 1'b0, h: 1'b0, c: a8[0]};
            end
            OP_RLA, OP_RL: begin
                o_result = {8'd0, a8[6:0], cin};
                o_flags  = '{z: (i_item.op == OP_RL) && ({a8[6:0], cin} == 8'd0),
                             n: 1'b0, h: 1'b0, c: a8[7]};
            end
            OP_RRA, OP_RR: begin
                o_result = {8'd0, cin, a8[7:1]};
                o_flags  = '{z: (i_item.op == OP_RR) && ({cin, a8[7:1]} == 8'd0),
                             n: 1'b0, h: 1'b0, c: a8[0]};
            end
            OP_SLA: begin
                o_result = {8'd0, a8[6:0], 1'b0};
                o_flags  = '{z: (a8[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            OP_SRA: begin
                o_result = {8'd0, a8[7], a8[7:1]};
                o_flags  = '{z: (a8[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            OP_SRL: begin
                o_result = {8'd0, 1'b0, a8[7:1]};
                o_flags  = '{z: (a8[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a8[0]};
            end
            OP_SWAP: begin
                o_result = {8'd0, a8[3:0], a8[7:4]};
                o_flags  = '{z: (a8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_BIT: begin
                o_flags = '{z: ((a8 & mask8) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
            end
            OP_SET: begin
                o_result = {8'd0, a8 | mask8};
            end
            OP_RES: begin
                o_result = {8'd0, a8 & ~mask8};
            end
            OP_CCF: begin
                o_flags = '{z: i_item.flags.z, n: 1'b0, h: 1'b0, c: ~cin};
            end
            OP_SCF: begin
                o_flags = '{z: i_item.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            OP_ADDHL: begin
                o_result = hl17[15:0];
                o_flags  = '{z: i_item.flags.z, n: 1'b0, h: hl_h13[12], c: hl17[16]};
            end
            OP_ADDSP: begin
                o_result = sp16;
                o_flags  = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
            end
            OP_INC16: begin
                o_result = i_item.a + 16'd1;
            end
            OP_DEC16: begin
                o_result = i_item.a - 16'd1;
            end
            default: begin
                o_result = i_item.a;
                o_flags  = i_item.flags;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/eight_bit_cpu_alu_flags.sv]
// Top level: input register, ALU datapath, result register with stream handshakes.
// Depends on alu8f_pkg and alu8f_core.
//
// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   48     op[5:0], operand_a[21:6], operand_b[37:22],
//                       bit_index[40:38], flags_in[44:41], zero fill
// m_axis    out  24     result_value[15:0], flags_out[19:16], zero fill
//
// The block takes one item per cycle while m_axis is not stalled.
// The input register feeds the ALU, whose output lands in the result register.
// Reset clears both valid bits only; payload registers are not reset.
// A stall on m_axis holds the result; the input register takes a new item while
// it is empty or the result register is empty or being drained in the same cycle.
`default_nettype none

module eight_bit_cpu_alu_flags (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // op, operand_a, operand_b, bit_index, flags_in, zero fill
    input  wire logic [47:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // result_value, flags_out, zero fill
    output logic [23:0]      o_m_axis_tdata
);
    import alu8f_pkg::*;

    logic        r_in_valid;
    t_alu_in     r_in;
    logic        r_out_valid;
    logic [15:0] r_out_result;
    t_flags      r_out_flags;

    logic        out_ready;
    logic        in_accept;
    t_alu_in     n_in;
    logic [15:0] alu_result;
    t_flags      alu_flags;

    // Stage advance conditions
    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_ready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Unpack the incoming transaction
    assign n_in.op        = i_s_axis_tdata[5:0];
    assign n_in.a         = i_s_axis_tdata[21:6];
    assign n_in.b         = i_s_axis_tdata[37:22];
    assign n_in.bit_index = i_s_axis_tdata[40:38];
    assign n_in.flags     = i_s_axis_tdata[44:41];

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_accept) begin
            r_in <= n_in;
        end
    end

    alu8f_core u_core (
        .i_item   (r_in),
        .o_result (alu_result),
        .o_flags  (alu_flags)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (out_ready && r_in_valid) begin
            r_out_result <= alu_result;
            r_out_flags  <= alu_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_flags, r_out_result};

    // An accepted item reaches the input register
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted item not held in input register");

    // A registered item moves on to the result register when it has room
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> o_m_axis_tvalid)
        else $error("item lost between input and result register");

    // Compare leaves the operand unchanged and sets N
    a_cp_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready && (r_in.op == OP_CP))
        |=> ((r_out_result == $past(r_in.a)) && r_out_flags.n))
        else $error("compare altered the operand or missed N");

endmodule

`default_nettype wire

[sim/tb_eight_bit_cpu_alu_flags.sv]
// Self-checking testbench for eight_bit_cpu_alu_flags: streams ALU operations
// and checks each result value and flag word against a built-in predictor.
// Depends on alu8f_pkg and the eight_bit_cpu_alu_flags RTL.
`timescale 1ns / 100ps

module tb_eight_bit_cpu_alu_flags;

    import alu8f_pkg::*;

    // Highest code the op field can carry; codes past OP_DEC16 pass through
    localparam logic [5:0] OP_CODE_MAX = 6'd63;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 35;

    // Expected transaction on m_axis: flags in the upper bits, as in tdata
    typedef struct packed {
        logic [3:0]  flags;
        logic [15:0] value;
    } t_alu_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // op, operand_a, operand_b, bit_index, flags_in, zero fill
    logic [47:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // result_value, flags_out, zero fill
    logic [23:0] o_m_axis_tdata;

    logic [47:0] op_backlog[$];
    t_alu_result results_due[$];
    int          sent_cnt;
    int          rcvd_cnt;
    int          mismatches;
    int          stall_cycles;
    logic        timed_out;

    eight_bit_cpu_alu_flags dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Compute the ALU result and outgoing flags for one operation
    function automatic t_alu_result alu_expect(input logic [5:0] op, input logic [15:0] a16,
                                               input logic [15:0] b16, input logic [2:0] bi,
                                               input t_flags f);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic [7:0]  msk;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [12:0] s13;
        logic [16:0] s17;
        logic [15:0] d;
        logic        cc;
        logic        hb;
        logic        cb;
        t_alu_result res;
        a = a16[7:0];
        b = b16[7:0];
        msk = 8'd1 << bi;
        res.value = a16;
        res.flags = f;
        case (op)
            OP_ADD, OP_ADC: begin
                cc = (op == OP_ADC) ? f.c : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + {8'd0, cc};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cc};
                res.value = {8'h00, s9[7:0]};
                res.flags = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                cc = (op == OP_SBC) ? f.c : 1'b0;
                r8 = a - b - {7'd0, cc};
                hb = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cc});
                cb = {1'b0, a} < ({1'b0, b} + {8'd0, cc});
                res.flags = {r8 == 8'h00, 1'b1, hb, cb};
                if (op != OP_CP) begin
                    res.value = {8'h00, r8};
                end
            end
            OP_AND: begin
                r8 = a & b;
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR, OP_OR: begin
                r8 = (op == OP_XOR) ? (a ^ b) : (a | b);
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 3'b000};
            end
            OP_INC: begin
                r8 = a + 8'd1;
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, f.c};
            end
            OP_DEC: begin
                r8 = a - 8'd1;
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hf, f.c};
            end
            OP_DAA: begin
                // Adjust in 16 bits so the carry out lands in bit 8
                d = {8'h00, a};
                if (!f.n) begin
                    if (f.h || d[3:0] > 4'h9) d = d + 16'h0006;
                    if (f.c || d > 16'h009f) d = d + 16'h0060;
                end else begin
                    if (f.h) begin
                        d = d - 16'h0006;
                        if (!f.c) d = {8'h00, d[7:0]};
                    end
                    if (f.c) d = d - 16'h0060;
                end
                res.value = {8'h00, d[7:0]};
                res.flags = {d[7:0] == 8'h00, f.n, 1'b0, f.c | d[8]};
            end
            OP_CPL: begin
                res.value = {8'h00, ~a};
                res.flags = {f.z, 1'b1, 1'b1, f.c};
            end
            OP_RLCA, OP_RLC: begin
                r8 = {a[6:0], a[7]};
                res.value = {8'h00, r8};
                res.flags = {(op == OP_RLC) && (r8 == 8'h00), 2'b00, a[7]};
            end
            OP_RRCA, OP_RRC: begin
                r8 = {a[0], a[7:1]};
                res.value = {8'h00, r8};
                res.flags = {(op == OP_RRC) && (r8 == 8'h00), 2'b00, a[0]};
            end
            OP_RLA, OP_RL: begin
                r8 = {a[6:0], f.c};
                res.value = {8'h00, r8};
                res.flags = {(op == OP_RL) && (r8 == 8'h00), 2'b00, a[7]};
            end
            OP_RRA, OP_RR: begin
                r8 = {f.c, a[7:1]};
                res.value = {8'h00, r8};
                res.flags = {(op == OP_RR) && (r8 == 8'h00), 2'b00, a[0]};
            end
            OP_SLA: begin
                r8 = {a[6:0], 1'b0};
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 2'b00, a[7]};
            end
            OP_SRA, OP_SRL: begin
                r8 = {(op == OP_SRA) ? a[7] : 1'b0, a[7:1]};
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 2'b00, a[0]};
            end
            OP_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                res.value = {8'h00, r8};
                res.flags = {r8 == 8'h00, 3'b000};
            end
            OP_BIT: res.flags = {~a[bi], 1'b0, 1'b1, f.c};
            OP_SET: res.value = {8'h00, a | msk};
            OP_RES: res.value = {8'h00, a & ~msk};
            OP_CCF: res.flags = {f.z, 2'b00, ~f.c};
            OP_SCF: res.flags = {f.z, 2'b00, 1'b1};
            OP_ADDHL: begin
                s17 = {1'b0, a16} + {1'b0, b16};
                s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                res.value = s17[15:0];
                res.flags = {f.z, 1'b0, s13[12], s17[16]};
            end
            OP_ADDSP: begin
                // Signed byte offset; H and C come from the unsigned low byte
                res.value = a16 + {{8{b[7]}}, b};
                s5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
                s9 = {1'b0, a16[7:0]} + {1'b0, b};
                res.flags = {2'b00, s5[4], s9[8]};
            end
            OP_INC16: res.value = a16 + 16'd1;
            OP_DEC16: res.value = a16 - 16'd1;
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_op(input logic [5:0] op, input logic [15:0] a,
                                     input logic [15:0] b, input logic [2:0] bi,
                                     input logic [3:0] f);
        op_backlog.push_back({3'b000, f, bi, b, a, op});
    endfunction

    // Operand with extra weight on the extremes and on byte-sized values
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit all_drained();
        return op_backlog.size() == 0 && !i_s_axis_tvalid && results_due.size() == 0;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: record accepted transactions, then present the next operation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                results_due.push_back(alu_expect(i_s_axis_tdata[5:0], i_s_axis_tdata[21:6],
                                                 i_s_axis_tdata[37:22], i_s_axis_tdata[40:38],
                                                 i_s_axis_tdata[44:41]));
                sent_cnt++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (op_backlog.size() != 0 &&
                    ((sent_cnt >= 1000 && sent_cnt < 1400) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= op_backlog.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                rcvd_cnt++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.value) begin
                        mismatches++;
                        $display("%0t: result_value mismatch, expected %h, actual %h",
                                 $time, want.value, o_m_axis_tdata[15:0]);
                    end
                    if (o_m_axis_tdata[19:16] !== want.flags) begin
                        mismatches++;
                        $display("%0t: flags_out mismatch, expected %b, actual %b",
                                 $time, want.flags, o_m_axis_tdata[19:16]);
                    end
                end
            end
            i_m_axis_tready <= (rcvd_cnt >= 1000 && rcvd_cnt < 1400) ||
                               ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: flag a run that stops moving transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                timed_out <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int k;
        logic [5:0] op;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        sent_cnt        = 0;
        rcvd_cnt        = 0;
        mismatches      = 0;
        stall_cycles    = 0;
        timed_out       = 1'b0;

        // Every operation plus an unused code, alternating all-ones and all-zero fields
        for (k = OP_ADD; k <= OP_DEC16 + 1; k++) begin
            op = (k > OP_DEC16) ? OP_CODE_MAX : 6'(k);
            if (k % 2 == 0) queue_op(op, 16'hffff, 16'hffff, 3'd7, 4'hf);
            else queue_op(op, 16'h0000, 16'h0000, 3'd0, 4'h0);
        end
        // Decimal adjust after add and after subtract, with and without H and C
        queue_op(OP_DAA, 16'h003c, 16'h0000, 3'd0, 4'b0000);
        queue_op(OP_DAA, 16'h009a, 16'h0000, 3'd0, 4'b0000);
        queue_op(OP_DAA, 16'h0099, 16'h0000, 3'd0, 4'b0001);
        queue_op(OP_DAA, 16'h000f, 16'h0000, 3'd0, 4'b0110);
        queue_op(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0101);
        queue_op(OP_DAA, 16'h0005, 16'h0000, 3'd0, 4'b0111);
        // Negative offsets to SP, half and full carries on HL
        queue_op(OP_ADDSP, 16'h00ff, 16'h0080, 3'd0, 4'hf);
        queue_op(OP_ADDSP, 16'h0008, 16'h00ff, 3'd0, 4'h0);
        queue_op(OP_ADDHL, 16'h0fff, 16'h0001, 3'd0, 4'h8);
        queue_op(OP_ADDHL, 16'hffff, 16'h0001, 3'd0, 4'h0);
        // Carry in on borrow and add, nibble wrap on inc and dec, compare keeps a
        queue_op(OP_SBC, 16'h0000, 16'h0000, 3'd0, 4'b0001);
        queue_op(OP_ADC, 16'h000f, 16'h0000, 3'd0, 4'b0001);
        queue_op(OP_INC, 16'h00ff, 16'h0000, 3'd0, 4'h0);
        queue_op(OP_DEC, 16'h0010, 16'h0000, 3'd0, 4'h0);
        queue_op(OP_CP, 16'h1234, 16'h0034, 3'd0, 4'h0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold off the random part until the directed results are all back
        while (!all_drained() && !timed_out) @(posedge i_clk);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 90) op = 6'($urandom_range(OP_ADD, OP_DEC16));
            else op = 6'($urandom_range(OP_DEC16 + 1, OP_CODE_MAX));
            queue_op(op, pick_word(), pick_word(), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)));
        end

        while (!all_drained() && !timed_out) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0 && !timed_out) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
